// ===== hw/rtl/fixed_point_q24_8_alu_top_assert.svh =====
// assertion macros shared by the alu top level
`ifndef FIXED_POINT_Q24_8_ALU_TOP_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alu assertion failed");

// next-cycle implication, disabled while in reset
`define FPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alu assertion failed");

`endif

// ===== hw/rtl/fpq_alu_pkg.sv =====
package fpq_alu_pkg;

  // default word layout
  localparam int WORD_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 8;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // request kinds
  localparam logic [3:0] KIND_ADD      = 4'd0;
  localparam logic [3:0] KIND_SUB      = 4'd1;
  localparam logic [3:0] KIND_MUL      = 4'd2;
  localparam logic [3:0] KIND_DIV      = 4'd3;
  localparam logic [3:0] KIND_MIN      = 4'd4;
  localparam logic [3:0] KIND_MAX      = 4'd5;
  localparam logic [3:0] KIND_INC      = 4'd6;
  localparam logic [3:0] KIND_DEC      = 4'd7;
  localparam logic [3:0] KIND_TO_INT   = 4'd8;
  localparam logic [3:0] KIND_FROM_INT = 4'd9;

  // work class chosen by the front
  localparam logic [1:0] OP_FAST = 2'd0;
  localparam logic [1:0] OP_MUL  = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               saturated;
    logic               divide_by_zero;
  } out_res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic        neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] res;
    logic        sat;
    logic        dz;
    logic        lt;
    logic        eq;
    logic        gt;
  } cls_t;

endpackage

// ===== hw/rtl/fpq_alu_front.sv =====
module fpq_alu_front #(
  parameter int WORD_WIDTH    = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  fpq_alu_pkg::in_req_t in_req,
  output logic                cls_valid,
  output fpq_alu_pkg::cls_t   cls
);
  import fpq_alu_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int XW = W + F + 2;
  localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] MINV = ~MAXV;

  logic signed [W-1:0]  a, b;
  logic signed [XW-1:0] ax, bx;
  logic [W-1:0]         mag_a, mag_b, toq, tor, mm;
  logic                 lt, eq, gt;
  logic [32:0]          c_add, c_sub, c_inc, c_dec, c_from;
  cls_t                 cls_nxt, cls_r;
  logic                 valid_r;

  // clamp a wide signed value into the word, flag in the top bit
  function automatic logic [32:0] clampw(input logic signed [XW-1:0] v);
    logic [W-1:0] r;
    logic         s;
    s = 1'b0;
    if (v > MAXV) begin
      r = MAXV[W-1:0];
      s = 1'b1;
    end else if (v < MINV) begin
      r = MINV[W-1:0];
      s = 1'b1;
    end else begin
      r = v[W-1:0];
    end
    return {s, 32'($signed(r))};
  endfunction

  // operands from their low word bits
  assign a  = $signed(in_req.operand_a[W-1:0]);
  assign b  = $signed(in_req.operand_b[W-1:0]);
  assign ax = {{(XW-W){a[W-1]}}, a};
  assign bx = {{(XW-W){b[W-1]}}, b};

  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;

  assign lt = a < b;
  assign eq = a == b;
  assign gt = a > b;

  // combinational results
  assign c_add  = clampw(ax + bx);
  assign c_sub  = clampw(ax - bx);
  assign c_inc  = clampw(ax + XW'(1));
  assign c_dec  = clampw(ax - XW'(1));
  assign c_from = clampw(ax <<< F);
  assign toq    = mag_a >> F;
  assign tor    = a[W-1] ? (~toq + 1'b1) : toq;
  assign mm     = lt ? a : b;

  // classify
  always_comb begin
    cls_nxt       = '0;
    cls_nxt.op    = OP_FAST;
    cls_nxt.neg   = a[W-1] ^ b[W-1];
    cls_nxt.mag_a = 32'(mag_a);
    cls_nxt.mag_b = 32'(mag_b);
    cls_nxt.lt    = lt;
    cls_nxt.eq    = eq;
    cls_nxt.gt    = gt;
    unique case (in_req.kind)
      KIND_ADD:      {cls_nxt.sat, cls_nxt.res} = c_add;
      KIND_SUB:      {cls_nxt.sat, cls_nxt.res} = c_sub;
      KIND_MUL:      cls_nxt.op = OP_MUL;
      KIND_DIV: begin
        if (mag_b == '0) begin
          cls_nxt.dz  = 1'b1;
          cls_nxt.sat = 1'b1;
          cls_nxt.res = a[W-1] ? 32'($signed(MINV[W-1:0])) : 32'($signed(MAXV[W-1:0]));
        end else begin
          cls_nxt.op = OP_DIV;
        end
      end
      KIND_MIN:      cls_nxt.res = 32'($signed(mm));
      KIND_MAX:      cls_nxt.res = lt ? 32'($signed(b)) : 32'($signed(a));
      KIND_INC:      {cls_nxt.sat, cls_nxt.res} = c_inc;
      KIND_DEC:      {cls_nxt.sat, cls_nxt.res} = c_dec;
      KIND_TO_INT:   cls_nxt.res = 32'($signed(tor));
      KIND_FROM_INT: {cls_nxt.sat, cls_nxt.res} = c_from;
      default:       cls_nxt.res = '0;
    endcase
  end

  // front register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r <= cls_nxt;
    end
  end

  assign cls_valid = valid_r;
  assign cls       = cls_r;

endmodule

// ===== hw/rtl/fpq_alu_queue.sv =====
module fpq_alu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fpq_alu_pkg::cls_t push_data,
  output logic              head_valid,
  output fpq_alu_pkg::cls_t head_data,
  output logic              full
);
  import fpq_alu_pkg::*;

  cls_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_r, rd_r;
  logic [QUEUE_AW:0]     cnt_r;
  logic                  pop;

  // the back end takes the head whenever one is there
  assign head_valid = cnt_r != '0;
  assign pop        = head_valid;
  assign head_data  = mem_r[rd_r];
  assign full       = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/fpq_alu_back.sv =====
module fpq_alu_back #(
  parameter int WORD_WIDTH    = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  fpq_alu_pkg::cls_t     head_data,
  output logic                  out_valid,
  output fpq_alu_pkg::out_res_t out_data
);
  import fpq_alu_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int NB = W + F;
  localparam int SW = 2 * W + 1;
  localparam logic [SW-1:0] LIM = SW'(1) << (W - 1);

  typedef struct packed {
    logic          v;
    logic [1:0]    op;
    logic          neg;
    logic          lt;
    logic          eq;
    logic          gt;
    logic          sat;
    logic          dz;
    logic [31:0]   res;
    logic [W-1:0]  den;
    logic [NB-1:0] num;
    logic [W-1:0]  rem;
    logic [NB-1:0] quo;
    logic [2*W-1:0] prod;
  } stg_t;

  stg_t        st_r   [NB];
  stg_t        st_nxt [NB];
  stg_t        s0, last;
  logic [NB:0] qr;
  logic [32:0] div_c;
  logic        out_valid_r;
  out_res_t    out_r;

  // one restoring division step
  function automatic stg_t divstep(input stg_t s);
    stg_t         o;
    logic [W:0]   t;
    logic         ge;
    o   = s;
    t   = {s.rem, s.num[NB-1]};
    ge  = t >= {1'b0, s.den};
    o.rem = ge ? W'(t - {1'b0, s.den}) : t[W-1:0];
    o.quo = {s.quo[NB-2:0], ge};
    o.num = s.num << 1;
    return o;
  endfunction

  // apply sign and clamp a rounded magnitude
  function automatic logic [32:0] sclamp(input logic [SW-1:0] q, input logic neg);
    logic [W-1:0] r;
    logic         s;
    s = neg ? (q > LIM) : (q > LIM - SW'(1));
    if (s) begin
      r = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r = neg ? (~q[W-1:0] + 1'b1) : q[W-1:0];
    end
    return {s, 32'($signed(r))};
  endfunction

  // stage zero loads the head, multiplies and starts the division
  always_comb begin
    s0      = '0;
    s0.v    = head_valid;
    s0.op   = head_data.op;
    s0.neg  = head_data.neg;
    s0.lt   = head_data.lt;
    s0.eq   = head_data.eq;
    s0.gt   = head_data.gt;
    s0.sat  = head_data.sat;
    s0.dz   = head_data.dz;
    s0.res  = head_data.res;
    s0.den  = head_data.mag_b[W-1:0];
    s0.num  = {head_data.mag_a[W-1:0], {F{1'b0}}};
    st_nxt[0]      = divstep(s0);
    st_nxt[0].prod = head_data.mag_a[W-1:0] * head_data.mag_b[W-1:0];
  end

  // remaining division steps; stage one also rounds the product
  for (genvar i = 1; i < NB; i++) begin : g_stage
    if (i == 1) begin : g_mul
      logic [SW-1:0] ps;
      logic [32:0]   mc;
      assign ps = ({1'b0, st_r[0].prod} + (SW'(1) << (F - 1))) >> F;
      assign mc = sclamp(ps, st_r[0].neg);
      always_comb begin
        st_nxt[i] = divstep(st_r[i-1]);
        if (st_r[i-1].op == OP_MUL) begin
          {st_nxt[i].sat, st_nxt[i].res} = mc;
        end
      end
    end else begin : g_div
      assign st_nxt[i] = divstep(st_r[i-1]);
    end
  end

  // stage registers
  for (genvar i = 0; i < NB; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i].v <= 1'b0;
      end else begin
        st_r[i].v <= st_nxt[i].v;
      end
    end

    always_ff @(posedge clk) begin
      st_r[i][$bits(stg_t)-2:0] <= st_nxt[i][$bits(stg_t)-2:0];
    end
  end

  // division rounding, half away from zero
  assign last  = st_r[NB-1];
  assign qr    = {1'b0, last.quo} + (NB+1)'({last.rem, 1'b0} >= {1'b0, last.den});
  assign div_c = sclamp(SW'(qr), last.neg);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.v;
    end
  end

  always_ff @(posedge clk) begin
    out_r.a_less         <= last.lt;
    out_r.a_equal        <= last.eq;
    out_r.a_greater      <= last.gt;
    out_r.divide_by_zero <= last.dz;
    if (last.op == OP_DIV) begin
      out_r.saturated <= div_c[32];
      out_r.result    <= div_c[31:0];
    end else begin
      out_r.saturated <= last.sat;
      out_r.result    <= last.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/fixed_point_q24_8_alu_top.sv =====
// channel   ports                         direction  handshake
// request   start, busy, in_data          in         accepted when start and not busy
// result    out_valid, out_data           out        one-cycle strobe, no backpressure
//
// one request per cycle; each request passes through the front register,
// the queue, the one-bit-per-stage divider that all kinds pass through in
// step, and the output register. synchronous active-low reset clears
// all valid bits and queue pointers. busy rises only if the front/back queue
// fills, which never happens since the back end drains it every cycle.
module fixed_point_q24_8_alu_top #(
  parameter int WORD_WIDTH    = fpq_alu_pkg::WORD_WIDTH_DEF,
  parameter int FRACTION_BITS = fpq_alu_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  fpq_alu_pkg::in_req_t  in_data,
  output logic                  out_valid,
  output fpq_alu_pkg::out_res_t out_data
);
  import fpq_alu_pkg::*;

`include "fixed_point_q24_8_alu_top_assert.svh"

  localparam int LAT = WORD_WIDTH + FRACTION_BITS + 3;

  logic take;
  logic cls_valid;
  cls_t cls;
  logic head_valid;
  cls_t head_data;
  logic q_full;

  assign take = start && !busy;
  assign busy = q_full;

  // classify incoming requests
  fpq_alu_front #(
    .WORD_WIDTH   (WORD_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_req   (in_data),
    .cls_valid(cls_valid),
    .cls      (cls)
  );

  // decoupling queue
  fpq_alu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cls_valid),
    .push_data (cls),
    .head_valid(head_valid),
    .head_data (head_data),
    .full      (q_full)
  );

  // multiply, divide and result assembly
  fpq_alu_back #(
    .WORD_WIDTH   (WORD_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_data (head_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // checks
  `FPQ_ASSERT_IMP(a_cmp_onehot, out_valid, $onehot({out_data.a_less, out_data.a_equal, out_data.a_greater}))
  `FPQ_ASSERT_IMP(a_dz_sat, out_valid && out_data.divide_by_zero, out_data.saturated)
  `FPQ_ASSERT_IMP(a_latency, out_valid, $past(start && !busy, LAT))
  `FPQ_ASSERT_NEXT(a_no_fill, head_valid, !busy)

endmodule
